@@ hw/rtl/hpfm_pkg.sv @@
`default_nettype none

package hpfm_pkg;

   // fixed field widths
   localparam int HYST_W     = 23;
   localparam int RATE_W     = 19;
   localparam int PERIOD_W   = 16;
   localparam int FREQ_W     = 19;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // parameter defaults
   localparam int DEF_COUNT_WIDTH  = 16;
   localparam int DEF_SAMPLE_WIDTH = 24;

   // register reset values and the period limit
   localparam logic [HYST_W-1:0]   HYST_RESET = 23'd50;
   localparam logic [RATE_W-1:0]   RATE_RESET = 19'd44100;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HYSTERESIS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATE       = 8'd1;

   // flags of the shared subtractor
   typedef struct packed {
      logic neg;
      logic zero;
   } sub_flags_type;

endpackage

`default_nettype wire

@@ hw/rtl/hpfm_sub.sv @@
`default_nettype none

module hpfm_sub
   import hpfm_pkg::*;
#(
   parameter int WIDTH = 34
) (
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   output logic      [WIDTH-1:0] diff,
   output sub_flags_type         flags
);

   always_comb begin
      diff       = op_a - op_b;
      flags.neg  = diff[WIDTH-1];
      flags.zero = (diff == '0);
   end

endmodule

`default_nettype wire

@@ hw/rtl/hysteresis_period_frequency_meter.sv @@
`default_nettype none

// Peak/valley hysteresis frequency meter. Each request carries one signed audio
// sample. The block follows the running peak (rising) or valley (falling) and
// flips direction once a sample moves more than the hysteresis register away
// from that extremum. On every falling-to-rising turn it returns one response:
// the sample count since the previous turn (saturated to 16 bits) and the
// rate register divided by that count, truncated (zero for a count of zero).
// Samples that cause no turn return nothing. All work runs through a single
// shared subtractor under a small sequencer: an accepted sample goes through
// a direction test and, if needed, a hysteresis test, one subtract each,
// before the block is ready again; a turn adds a restoring division, one
// quotient bit per cycle, and then loads the response register. A finished
// response waits in its own register, so the next request is taken while
// it is still stalled; only the next turn waits for it to leave.
// Configuration writes are always accepted and must be made while idle.

module hysteresis_period_frequency_meter
   import hpfm_pkg::*;
#(
   parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [SAMPLE_WIDTH-1:0] req_sample,

   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [PERIOD_W-1:0]     rsp_period_samples,
   output logic      [FREQ_W-1:0]       rsp_frequency_hz,

   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int RANGE_W = (RATE_W > COUNT_WIDTH) ? RATE_W : COUNT_WIDTH;
   localparam int REM_W   = RANGE_W + 1;
   localparam int UNIT_W0 = (SAMPLE_WIDTH + 2 > HYST_W + 1) ? SAMPLE_WIDTH + 2 : HYST_W + 1;
   localparam int UNIT_W  = (UNIT_W0 > REM_W + 1) ? UNIT_W0 : REM_W + 1;
   localparam int CMP_W   = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
   localparam int STEP_W  = $clog2(RATE_W);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIFF = 3'd1;
   localparam logic [2:0] S_HYST = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [HYST_W-1:0]        hyst_ff, hyst_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic                     rising_ff, rising_in;
   logic [SAMPLE_WIDTH-1:0]  peak_ff, peak_in;
   logic [SAMPLE_WIDTH-1:0]  valley_ff, valley_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic [SAMPLE_WIDTH-1:0]  smp_ff, smp_in;
   logic [UNIT_W-1:0]        diff_ff, diff_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [RATE_W-1:0]        quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]   divisor_ff, divisor_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0]      period_ff, period_in;
   logic [FREQ_W-1:0]        freq_ff, freq_in;

   logic [UNIT_W-1:0]        op_a, op_b, unit_diff;
   sub_flags_type            unit_flags;
   logic [UNIT_W-1:0]        smp_ext, peak_ext, valley_ext;
   logic [REM_W-1:0]         rem_shift;
   logic [COUNT_WIDTH-1:0]   count_inc;
   logic [CMP_W-1:0]         cnt_wide;

   hpfm_sub #(
      .WIDTH (UNIT_W)
   ) u_sub (
      .op_a  (op_a),
      .op_b  (op_b),
      .diff  (unit_diff),
      .flags (unit_flags)
   );

   assign smp_ext    = {{(UNIT_W-SAMPLE_WIDTH){smp_ff[SAMPLE_WIDTH-1]}}, smp_ff};
   assign peak_ext   = {{(UNIT_W-SAMPLE_WIDTH){peak_ff[SAMPLE_WIDTH-1]}}, peak_ff};
   assign valley_ext = {{(UNIT_W-SAMPLE_WIDTH){valley_ff[SAMPLE_WIDTH-1]}}, valley_ff};
   assign rem_shift  = {rem_ff[REM_W-2:0], quo_ff[RATE_W-1]};
   assign count_inc  = (count_ff == '1) ? count_ff : count_ff + COUNT_WIDTH'(1);
   assign cnt_wide   = CMP_W'(divisor_ff);

   // operand selection for the shared subtractor
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_DIFF: begin
            // distance moved back from the extremum, zero or negative means a new extremum
            if (rising_ff) begin
               op_a = peak_ext;
               op_b = smp_ext;
            end else begin
               op_a = smp_ext;
               op_b = valley_ext;
            end
         end
         S_HYST: begin
            // negative means the swing exceeds the hysteresis
            op_a = UNIT_W'(hyst_ff);
            op_b = diff_ff;
         end
         S_DIV: begin
            op_a = UNIT_W'(rem_shift);
            op_b = UNIT_W'(divisor_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      hyst_in      = hyst_ff;
      rate_in      = rate_ff;
      rising_in    = rising_ff;
      peak_in      = peak_ff;
      valley_in    = valley_ff;
      count_in     = count_ff;
      smp_in       = smp_ff;
      diff_in      = diff_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      period_in    = period_ff;
      freq_in      = freq_ff;

      if (csr_valid) begin
         if (csr_index == REG_HYSTERESIS) begin
            hyst_in = csr_data[HYST_W-1:0];
         end else if (csr_index == REG_RATE) begin
            rate_in = csr_data[RATE_W-1:0];
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               smp_in   = req_sample;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            if (unit_flags.neg || unit_flags.zero) begin
               // new extremum in the current direction
               if (rising_ff) begin
                  peak_in = smp_ff;
               end else begin
                  valley_in = smp_ff;
               end
               count_in = count_inc;
               state_in = S_IDLE;
            end else begin
               diff_in  = unit_diff;
               state_in = S_HYST;
            end
         end
         S_HYST: begin
            if (!unit_flags.neg) begin
               count_in = count_inc;
               state_in = S_IDLE;
            end else if (rising_ff) begin
               rising_in = 1'b0;
               valley_in = smp_ff;
               count_in  = count_inc;
               state_in  = S_IDLE;
            end else begin
               // falling-to-rising turn: start the division
               rising_in  = 1'b1;
               peak_in    = smp_ff;
               divisor_in = count_ff;
               count_in   = '0;
               rem_in     = '0;
               quo_in     = rate_ff;
               step_in    = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            if (unit_flags.neg) begin
               rem_in = rem_shift;
            end else begin
               rem_in = unit_diff[REM_W-1:0];
            end
            quo_in  = {quo_ff[RATE_W-2:0], !unit_flags.neg};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(RATE_W - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (cnt_wide > CMP_W'(PERIOD_MAX)) begin
                  period_in = PERIOD_MAX;
               end else begin
                  period_in = PERIOD_W'(cnt_wide);
               end
               freq_in  = (divisor_ff == '0) ? '0 : FREQ_W'(quo_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hyst_ff      <= HYST_RESET;
         rate_ff      <= RATE_RESET;
         rising_ff    <= 1'b1;
         peak_ff      <= '0;
         valley_ff    <= '0;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hyst_ff      <= hyst_in;
         rate_ff      <= rate_in;
         rising_ff    <= rising_in;
         peak_ff      <= peak_in;
         valley_ff    <= valley_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff     <= smp_in;
      diff_ff    <= diff_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
      period_ff  <= period_in;
      freq_ff    <= freq_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_period_samples = period_ff;
   assign rsp_frequency_hz   = freq_ff;
   assign csr_ready          = 1'b1;

endmodule

`default_nettype wire

@@ tb/tb_hysteresis_period_frequency_meter.sv @@
`default_nettype none

module tb_hysteresis_period_frequency_meter;
   import hpfm_pkg::*;

   localparam int     SW           = DEF_SAMPLE_WIDTH;
   localparam int     CW           = DEF_COUNT_WIDTH;
   localparam longint COUNT_MAX    = (longint'(1) << CW) - 1;
   localparam longint SAMPLE_MIN   = -(longint'(1) << (SW - 1));
   localparam longint SAMPLE_MAX   = (longint'(1) << (SW - 1)) - 1;
   localparam longint FULL_SPAN    = SAMPLE_MAX - SAMPLE_MIN;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     IDLE_MAX     = 15;
   localparam logic [HYST_W-1:0] HYST_FULL = {HYST_W{1'b1}};
   localparam logic [RATE_W-1:0] RATE_FULL = {RATE_W{1'b1}};

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [FREQ_W-1:0]   freq;
   } turn_result_type;

   class turn_scoreboard_type;
      logic [HYST_W-1:0] hyst;
      logic [RATE_W-1:0] rate;
      bit                rising;
      longint            peak;
      longint            valley;
      longint            count;
      turn_result_type   expected_turns[$];
      int                errors;
      int                turns_seen;

      function new();
         hyst       = HYST_RESET;
         rate       = RATE_RESET;
         rising     = 1'b1;
         peak       = 0;
         valley     = 0;
         count      = 0;
         errors     = 0;
         turns_seen = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_HYSTERESIS: hyst = data[HYST_W-1:0];
            REG_RATE:       rate = data[RATE_W-1:0];
            default: ;
         endcase
      endfunction

      // follows the extremum and queues a result on every valley-to-rising turn
      function void note_sample(logic [SW-1:0] raw);
         longint          s;
         longint          h;
         bit              turn;
         turn_result_type r;
         s    = longint'($signed(raw));
         h    = longint'(hyst);
         turn = 1'b0;
         if (!rising) begin
            if (s > valley) begin
               if (s - valley > h) begin
                  turn   = 1'b1;
                  rising = 1'b1;
                  peak   = s;
               end
            end else begin
               valley = s;
            end
         end else begin
            if (s < peak) begin
               if (peak - s > h) begin
                  rising = 1'b0;
                  valley = s;
               end
            end else begin
               peak = s;
            end
         end
         if (turn) begin
            r.period = (count > longint'(PERIOD_MAX)) ? PERIOD_MAX : count[PERIOD_W-1:0];
            r.freq   = (count == 0) ? '0 : FREQ_W'(longint'(rate) / count);
            expected_turns.push_back(r);
            count = 0;
         end else if (count < COUNT_MAX) begin
            count++;
         end
      endfunction

      function void check_result(logic [PERIOD_W-1:0] period, logic [FREQ_W-1:0] freq);
         turn_result_type want;
         turns_seen++;
         if (expected_turns.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: period %0d freq %0d", period, freq);
         end else begin
            want = expected_turns.pop_front();
            if (want.period !== period || want.freq !== freq) begin
               errors++;
               if (errors <= 10)
                  $display("result %0d: expected period %0d freq %0d, got period %0d freq %0d",
                           turns_seen, want.period, want.freq, period, freq);
            end
         end
      endfunction

      function int pending();
         return expected_turns.size();
      endfunction

      function void finish_check();
         if (expected_turns.size() != 0) begin
            errors += expected_turns.size();
            $display("%0d expected results never arrived", expected_turns.size());
         end
      endfunction
   endclass

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [SW-1:0]         req_sample         = '0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic [PERIOD_W-1:0]   rsp_period_samples;
   logic [FREQ_W-1:0]     rsp_frequency_hz;
   logic                  csr_valid          = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index          = '0;
   logic [CSR_DATA_W-1:0] csr_data           = '0;

   turn_scoreboard_type sb;
   int items_sent = 0;
   int csr_writes = 0;
   int gap_pct    = 0;
   int stall_pct  = 0;
   int stall_left = 0;

   longint first_swing [12] = '{0, -50, -51, -1, -100, -49,
                                SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 0};
   longint zero_swing  [5]  = '{5, 5, 4, 4, 5};
   longint full_swing  [6]  = '{SAMPLE_MIN, -1, 0, SAMPLE_MAX, -1, SAMPLE_MAX};

   hysteresis_period_frequency_meter i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_period_samples (rsp_period_samples),
      .rsp_frequency_hz   (rsp_frequency_hz),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_period_samples, rsp_frequency_hz);
         if (req_valid && !req_stall)
            sb.note_sample(req_sample);
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
            csr_writes++;
         end
      end
   end

   // response back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!reset && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, IDLE_MAX - 1);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [SW-1:0] to_sample(longint v);
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return v[SW-1:0];
   endfunction

   function automatic longint wobble(longint m);
      if (m == 0) return 0;
      return longint'($urandom_range(0, 32'(2 * m))) - m;
   endfunction

   task automatic send_sample(longint v);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, IDLE_MAX)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= to_sample(v);
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // upper data bits are junk, and a write to an unused index follows
   task automatic configure(logic [HYST_W-1:0] h, logic [RATE_W-1:0] r);
      logic [CSR_DATA_W-1:0] d;
      d = $urandom();
      d[HYST_W-1:0] = h;
      csr_write(REG_HYSTERESIS, d);
      d = $urandom();
      d[RATE_W-1:0] = r;
      csr_write(REG_RATE, d);
      csr_write(CSR_IDX_W'($urandom_range(2, 255)), $urandom());
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do begin
         repeat (DRAIN_CYCLES) @(posedge clock);
      end while (sb.pending() != 0);
   endtask

   // one falling then rising sweep with noise, now and then wide enough to break it
   task automatic send_wave_cycle();
      longint h;
      longint amp;
      longint lo;
      longint jitter;
      int     n_down;
      int     n_up;
      h = longint'(sb.hyst);
      case ($urandom_range(0, 2))
         0:       amp = h + 1 + longint'($urandom_range(0, 200));
         1:       amp = h + 1 + longint'($urandom_range(0, 100000));
         default: amp = h + 1 + longint'($urandom_range(0, 32'(FULL_SPAN - h - 1)));
      endcase
      if (amp > FULL_SPAN) amp = FULL_SPAN;
      lo     = SAMPLE_MIN + longint'($urandom_range(0, 32'(FULL_SPAN - amp)));
      jitter = ($urandom_range(0, 9) == 0) ? 2 * h + 2 : h / 2;
      n_down = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      n_up   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      for (int k = n_down; k >= 0; k--)
         send_sample(lo + amp * k / n_down + wobble(jitter));
      for (int k = 1; k <= n_up; k++)
         send_sample(lo + amp * k / n_up + wobble(jitter));
   endtask

   // lands on the current extremum, on the threshold around it, or just past it
   task automatic send_probe();
      longint h;
      longint d;
      h = longint'(sb.hyst);
      case ($urandom_range(0, 2))
         0:       d = 0;
         1:       d = h;
         default: d = h + 1;
      endcase
      send_sample(sb.rising ? sb.peak - d : sb.valley + d);
   endtask

   task automatic random_items(int n);
      int stop_at;
      int pick;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            send_wave_cycle();
         else if (pick < 85)
            send_sample(SAMPLE_MIN + longint'($urandom_range(0, 32'(FULL_SPAN))));
         else
            send_probe();
      end
   endtask

   task automatic run_phase(logic [HYST_W-1:0] h, logic [RATE_W-1:0] r, int n, int gp, int sp);
      stop_requests();
      wait_idle();
      configure(h, r);
      gap_pct   = gp;
      stall_pct = sp;
      random_items(n);
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings first, then zero hysteresis with zero rate, then full scale
      gap_pct   = 10;
      stall_pct = 5;
      foreach (first_swing[i]) send_sample(first_swing[i]);
      stop_requests();
      wait_idle();
      configure('0, '0);
      foreach (zero_swing[i]) send_sample(zero_swing[i]);
      stop_requests();
      wait_idle();
      configure(HYST_FULL, RATE_W'(384000));
      foreach (full_swing[i]) send_sample(full_swing[i]);

      run_phase(HYST_RESET, RATE_RESET, 300, 20, 8);
      run_phase('0, RATE_W'(384000), 250, 40, 15);
      run_phase(HYST_FULL, RATE_W'(1), 200, 0, 0);
      run_phase(HYST_W'($urandom_range(0, 2000)), RATE_W'($urandom_range(1, 384000)), 300, 25, 10);
      run_phase(HYST_W'($urandom_range(1000000, 8388607)), '0, 200, 10, 20);
      run_phase(HYST_W'($urandom_range(0, 500)), RATE_FULL, 150, 30, 5);
      run_phase(HYST_RESET, RATE_W'(48000), 150, 0, 0);

      stop_requests();
      wait_idle();
      sb.finish_check();
      $display("%0d samples sent, %0d results checked, %0d register writes",
               items_sent, sb.turns_seen, csr_writes);
      $display("swept hysteresis from zero to full scale and several rates, with gaps and stalls");
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/hpfm_pkg.sv
hw/rtl/hpfm_sub.sv
hw/rtl/hysteresis_period_frequency_meter.sv
tb/tb_hysteresis_period_frequency_meter.sv
